// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the range median filter.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is high.
`define RMF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define RMF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/rmf_pkg.sv -----
// ---------------------------------------------------------------------------
// Range median filter package
// Field widths, word types and the control bundle shared by the filter.
// ---------------------------------------------------------------------------
package rmf_pkg;

  localparam int HalfWindowDef = 2;
  localparam int RangeW        = 17;
  localparam int TagW          = 12;

  typedef struct packed {
    logic signed [RangeW-1:0] range_in;
    logic [TagW-1:0]          angle_tag_in;
    logic                     scan_start;
  } in_word_t;

  typedef struct packed {
    logic signed [RangeW-1:0] median_range;
    logic [TagW-1:0]          angle_tag_out;
  } out_word_t;

  typedef struct packed {
    logic shift;
    logic advance;
  } ctl_t;

endpackage

// ----- hdl/range_median_filter_5_top.sv -----
// A completed window is ranked into the cell registers, then held in the result.
// Throughput: one word per cycle, set by the ranking cells, unless result_stall.
// Each cell ranks its sample against the whole window in one stage.
// Reset clears the fill count and all valid flags; samples need no reset.
// ---------------------------------------------------------------------------
// Range median filter top level
// Sliding window median over the range samples of one scan.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module range_median_filter_5_top #(
  parameter int HALF_WINDOW = rmf_pkg::HalfWindowDef
) (
  input  logic                clk,
  input  logic                rst,
  input  rmf_pkg::in_word_t   sample,
  input  logic                sample_valid,
  output logic                sample_stall,
  output rmf_pkg::out_word_t  result,
  output logic                result_valid,
  input  logic                result_stall
);
  import rmf_pkg::*;

  localparam int WIN    = 2 * HALF_WINDOW + 1;
  localparam int RANK_W = $clog2(WIN);
  localparam int FILL_W = $clog2(WIN + 1);

  ctl_t                     ctl;
  logic                     accept;
  logic [FILL_W-1:0]        fill;
  logic [FILL_W-1:0]        fill_next;
  logic                     res_pend;
  logic                     rank_valid;
  logic [TagW-1:0]          ctr_tag;
  logic [TagW-1:0]          tag_line [HALF_WINDOW+1];
  logic signed [RangeW-1:0] taps [WIN];
  logic signed [RangeW-1:0] ranked [WIN];
  logic [RANK_W-1:0]        ranks [WIN];

  assign ctl.advance  = !result_valid || !result_stall;
  assign sample_stall = !ctl.advance;
  assign accept       = sample_valid && ctl.advance;
  assign ctl.shift    = accept;

  always_comb begin
    if (sample.scan_start) begin
      fill_next = FILL_W'(1);
    end else if (fill == FILL_W'(WIN)) begin
      fill_next = fill;
    end else begin
      fill_next = fill + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      res_pend   <= 1'b0;
      rank_valid <= 1'b0;
    end else if (ctl.advance) begin
      res_pend   <= accept && (fill_next == FILL_W'(WIN));
      rank_valid <= res_pend;
      if (accept) begin
        fill <= fill_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tag_line[0] <= sample.angle_tag_in;
      for (int i = 1; i <= HALF_WINDOW; i++) begin
        tag_line[i] <= tag_line[i-1];
      end
    end
    if (ctl.advance) begin
      ctr_tag <= tag_line[HALF_WINDOW];
    end
  end

  for (genvar g = 0; g < WIN; g++) begin : g_cell
    rmf_cell #(
      .WIN    (WIN),
      .INDEX  (g),
      .RANK_W (RANK_W)
    ) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .prev   ((g == 0) ? sample.range_in : taps[(g == 0) ? 0 : g - 1]),
      .win    (taps),
      .tap    (taps[g]),
      .ranked (ranked[g]),
      .rank   (ranks[g])
    );
  end

  rmf_select #(
    .WIN    (WIN),
    .HALF   (HALF_WINDOW),
    .RANK_W (RANK_W)
  ) u_select (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .rank_valid   (rank_valid),
    .ranks        (ranks),
    .vals         (ranked),
    .ctr_tag      (ctr_tag),
    .result       (result),
    .result_valid (result_valid)
  );

  // A pending median always comes from a full window of the current scan.
  `RMF_ASSERT(a_pend_full, clk, rst, res_pend |-> (fill == FILL_W'(WIN)), "no full window")
  // A scan start never yields a word for that same sample.
  `RMF_ASSERT(a_start_quiet, clk, rst, accept && sample.scan_start |=> !res_pend, "early word")
  // A new result word is always fed by the ranking stage.
  `RMF_ASSERT(a_out_src, clk, rst, $rose(result_valid) |-> $past(rank_valid), "unranked word")

endmodule

// ----- hdl/rmf_cell.sv -----
// ---------------------------------------------------------------------------
// Range median filter cell
// Holds one window sample, hands it to the next cell and ranks it.
// ---------------------------------------------------------------------------
module rmf_cell #(
  parameter int WIN    = 5,
  parameter int INDEX  = 0,
  parameter int RANK_W = $clog2(WIN)
) (
  input  logic                                 clk,
  input  rmf_pkg::ctl_t                        ctl,
  input  logic signed [rmf_pkg::RangeW-1:0]    prev,
  input  logic signed [rmf_pkg::RangeW-1:0]    win [WIN],
  output logic signed [rmf_pkg::RangeW-1:0]    tap,
  output logic signed [rmf_pkg::RangeW-1:0]    ranked,
  output logic [RANK_W-1:0]                    rank
);
  import rmf_pkg::*;

  logic [WIN-1:0]    ahead;
  logic [RANK_W-1:0] rank_next;

  // A sample is ordered ahead of this one if it is smaller, or equal and
  // newer, so that the ranks across the window form a permutation.
  always_comb begin
    rank_next = '0;
    for (int j = 0; j < WIN; j++) begin
      ahead[j]  = (win[j] < tap) || ((win[j] == tap) && (j < INDEX));
      rank_next = rank_next + RANK_W'(ahead[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      tap <= prev;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      rank   <= rank_next;
      ranked <= tap;
    end
  end

endmodule

// ----- hdl/rmf_select.sv -----
// ---------------------------------------------------------------------------
// Range median filter select
// Picks the middle-ranked sample and holds the result word.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rmf_select #(
  parameter int WIN    = 5,
  parameter int HALF   = 2,
  parameter int RANK_W = $clog2(WIN)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  rmf_pkg::ctl_t                        ctl,
  input  logic                                 rank_valid,
  input  logic [RANK_W-1:0]                    ranks [WIN],
  input  logic signed [rmf_pkg::RangeW-1:0]    vals [WIN],
  input  logic [rmf_pkg::TagW-1:0]             ctr_tag,
  output rmf_pkg::out_word_t                   result,
  output logic                                 result_valid
);
  import rmf_pkg::*;

  logic [WIN-1:0]    hit;
  logic [RangeW-1:0] med;

  always_comb begin
    med = '0;
    for (int i = 0; i < WIN; i++) begin
      hit[i] = (ranks[i] == RANK_W'(HALF));
      med    = med | (vals[i] & {RangeW{hit[i]}});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctl.advance) begin
      result_valid <= rank_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      result.median_range  <= $signed(med);
      result.angle_tag_out <= ctr_tag;
    end
  end

  // Exactly one sample of a full window holds the middle rank.
  `RMF_ASSERT(a_one_median, clk, rst, rank_valid |-> $onehot(hit), "median rank not unique")

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Range median filter testbench
// Streams laser scans of random length and content through the five-sample
// median filter and checks every result word against a scoreboard that keeps
// its own copy of the window. The source idles and the sink stalls at random.
// ---------------------------------------------------------------------------
module testbench;
  import rmf_pkg::*;

  localparam int WinSize    = 2 * HalfWindowDef + 1;
  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 80;

  typedef enum int {
    RANGE_NOISE,
    RANGE_SMOOTH,
    RANGE_EXTREME
  } range_mode_t;

  class median_scoreboard;
    logic signed [RangeW-1:0] taps [WinSize];
    logic [TagW-1:0]          tag_line [HalfWindowDef+1];
    int unsigned              fill = 0;
    out_word_t                expected_q [$];
    int unsigned              errors = 0;

    function logic signed [RangeW-1:0] window_median();
      logic signed [RangeW-1:0] srt [WinSize];
      logic signed [RangeW-1:0] v;
      int j;
      for (int i = 0; i < WinSize; i++) begin
        v = taps[i];
        j = i;
        while (j > 0 && srt[j-1] > v) begin
          srt[j] = srt[j-1];
          j--;
        end
        srt[j] = v;
      end
      return srt[HalfWindowDef];
    endfunction

    function void note_sample(in_word_t w);
      out_word_t want;
      if (w.scan_start) fill = 0;
      for (int i = WinSize - 1; i > 0; i--) taps[i] = taps[i-1];
      taps[0] = w.range_in;
      for (int i = HalfWindowDef; i > 0; i--) tag_line[i] = tag_line[i-1];
      tag_line[0] = w.angle_tag_in;
      if (fill < WinSize) fill++;
      if (fill == WinSize) begin
        want.median_range  = window_median();
        want.angle_tag_out = tag_line[HalfWindowDef];
        expected_q = {expected_q, want};
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: expected none, actual median %0d tag %0d",
                 $time, got.median_range, got.angle_tag_out);
        return;
      end
      want = expected_q.pop_front();
      if (got.median_range !== want.median_range) begin
        errors++;
        $display("%0t: median_range mismatch: expected %0d, actual %0d",
                 $time, want.median_range, got.median_range);
      end
      if (got.angle_tag_out !== want.angle_tag_out) begin
        errors++;
        $display("%0t: angle_tag_out mismatch: expected %0d, actual %0d",
                 $time, want.angle_tag_out, got.angle_tag_out);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  in_word_t  sample = '0;
  logic      sample_valid = 1'b0;
  logic      sample_stall;
  out_word_t result;
  logic      result_valid;
  logic      result_stall = 1'b0;

  median_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned words_sent = 0;
  logic [TagW-1:0] tag_next = '0;

  range_median_filter_5_top dut (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) sb.check_result(result);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic set_phase(input int p);
    case (p % 4)
      0: begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      1: begin
        send_idle_pct = 68;
        stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        stall_pct = 68;
      end
      default: begin
        send_idle_pct = 14;
        stall_pct = 14;
      end
    endcase
  endtask

  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample <= w;
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
    sb.note_sample(w);
    words_sent++;
  endtask

  task automatic send_fields(input int rng, input int tag, input bit start);
    in_word_t w;
    w.range_in     = rng[RangeW-1:0];
    w.angle_tag_in = tag[TagW-1:0];
    w.scan_start   = start;
    send_word(w);
  endtask

  function automatic logic signed [RangeW-1:0] pick_range(input range_mode_t mode,
                                                          input int base);
    int v;
    case (mode)
      RANGE_SMOOTH: begin
        if ($urandom_range(15) == 0) v = int'($urandom);
        else v = base + int'($urandom_range(200)) - 100;
      end
      RANGE_EXTREME: begin
        case ($urandom_range(4))
          0: v = -65536;
          1: v = 65535;
          2: v = 0;
          3: v = -1;
          default: v = int'($urandom);
        endcase
      end
      default: v = int'($urandom);
    endcase
    return v[RangeW-1:0];
  endfunction

  task automatic send_scan(input int len, input bit fresh, input bit random_tags);
    range_mode_t mode;
    int base;
    mode = range_mode_t'($urandom_range(2));
    base = int'($urandom_range(131071)) - 65536;
    if (!random_tags) tag_next = TagW'($urandom_range(4095));
    for (int k = 0; k < len; k++) begin
      send_fields(pick_range(mode, base),
                  random_tags ? int'($urandom_range(4095)) : int'(tag_next),
                  fresh && k == 0);
      tag_next = tag_next + TagW'(1);
    end
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int kind;
    int p;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    set_phase(0);

    send_fields(65535, 4095, 1'b1);
    send_fields(-65536, 0, 1'b0);
    send_fields(0, 2048, 1'b0);
    send_fields(-1, 1, 1'b0);
    send_fields(1, 4094, 1'b0);
    send_fields(-65536, 7, 1'b0);
    send_fields(65535, 8, 1'b0);
    send_fields(-2, 100, 1'b1);
    send_fields(2, 101, 1'b0);
    send_fields(3, 102, 1'b0);
    for (int k = 0; k < 6; k++) send_fields(-65536, 4090 + k, k == 0);
    for (int k = 0; k < 6; k++) send_fields(65535, 4095, k == 0);

    hold_req = 1'b1;
    send_scan(60, 1'b1, 1'b0);
    drain();

    p = 0;
    while (words_sent < 560) begin
      if (words_sent / 80 != p) begin
        p = words_sent / 80;
        set_phase(p);
        if (p == 4) drain();
      end
      kind = $urandom_range(9);
      if (kind < 8) send_scan($urandom_range(5, 40), 1'b1, 1'b0);
      else if (kind == 8) send_scan($urandom_range(1, 4), 1'b1, 1'b1);
      else send_scan($urandom_range(1, 10), 1'b0, 1'b1);
    end

    sample_valid <= 1'b0;
    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- range_median_filter_5_top.f -----
+incdir+hdl
hdl/rmf_pkg.sv
hdl/rmf_cell.sv
hdl/rmf_select.sv
hdl/range_median_filter_5_top.sv
sim/testbench.sv
